// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of the core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/tcis_pkg.sv -----
// Package of the teaching CPU step core: sizes, codes, opcodes, controller states
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package tcis_pkg;

    localparam int DW        = 8;
    localparam int MEM_DEPTH = 256;
    localparam int MEM_AW    = 8;
    localparam int REG_DEPTH = 16;
    localparam int REG_AW    = 4;

    localparam logic [8:0]    PC_LIMIT    = 9'd254;
    localparam logic [15:0]   HALT_WORD   = 16'hC000;
    localparam logic [MEM_AW-1:0] SCREEN_ADDR = 8'h00;

    localparam logic [3:0] OP_LOAD  = 4'h1;
    localparam logic [3:0] OP_IMM   = 4'h2;
    localparam logic [3:0] OP_STORE = 4'h3;
    localparam logic [3:0] OP_MOVE  = 4'h4;
    localparam logic [3:0] OP_ADD   = 4'h5;
    localparam logic [3:0] OP_FADD  = 4'h6;
    localparam logic [3:0] OP_JEQ   = 4'hB;
    localparam logic [3:0] OP_HALT  = 4'hC;

    typedef enum logic [1:0] {
        CMD_MEM_WR = 2'd0,
        CMD_EXEC   = 2'd1,
        CMD_MEM_RD = 2'd2,
        CMD_REG_RD = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_RUN     = 2'd0,
        ST_HALT    = 2'd1,
        ST_PCEND   = 2'd2,
        ST_ILLEGAL = 2'd3
    } t_run_status;

    typedef enum logic [1:0] {
        MRA_PC   = 2'd0,
        MRA_PC1  = 2'd1,
        MRA_LO   = 2'd2,
        MRA_ADDR = 2'd3
    } t_mem_ra;

    typedef enum logic {
        MWS_DATA = 1'b0,
        MWS_REG  = 1'b1
    } t_mem_wsrc;

    typedef enum logic [2:0] {
        RRA_R    = 3'd0,
        RRA_S    = 3'd1,
        RRA_T    = 3'd2,
        RRA_ZERO = 3'd3,
        RRA_ADDR = 3'd4
    } t_reg_ra;

    typedef enum logic [2:0] {
        RWS_MEM  = 3'd0,
        RWS_LO   = 3'd1,
        RWS_MOVE = 3'd2,
        RWS_ADD  = 3'd3,
        RWS_FLT  = 3'd4
    } t_reg_wsrc;

    typedef enum logic [1:0] {
        PCO_HOLD   = 2'd0,
        PCO_NEXT   = 2'd1,
        PCO_BRANCH = 2'd2
    } t_pc_op;

    typedef enum logic [1:0] {
        STO_NONE    = 2'd0,
        STO_HALT    = 2'd1,
        STO_ILLEGAL = 2'd2
    } t_st_op;

    typedef enum logic [4:0] {
        S_IDLE, S_MWR, S_MRD, S_MRDC, S_RRD, S_RRDC,
        S_F1, S_F2, S_F3, S_DEC, S_LDW, S_STW, S_MVW,
        S_AB, S_EX, S_FWB, S_RESP
    } t_state;

    typedef struct packed {
        logic      load_req;
        t_mem_ra   mem_ra;
        logic      mem_we;
        t_mem_wsrc mem_wsrc;
        t_reg_ra   reg_ra;
        logic      reg_we;
        t_reg_wsrc reg_wsrc;
        logic      cap_hi;
        logic      cap_lo;
        logic      cap_a;
        logic      cap_fsum;
        logic      cap_rd_mem;
        logic      cap_rd_reg;
        t_pc_op    pc_op;
        t_st_op    st_op;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] op;
        logic       r_zero;
        logic       halt_word;
        logic       running;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/core/tcis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/tcis_dpath.sv -----
// Datapath of the teaching CPU step core: main store, register file, PC,
// run status, float adder. Depends on tcis_pkg and tcis_ram.
`default_nettype none

module tcis_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_addr,
    input  logic [7:0]            i_data,
    input  tcis_pkg::t_dp_cmd     i_cmd,
    output tcis_pkg::t_dp_stat    o_stat,
    output logic [7:0]            o_read_data,
    output logic [7:0]            o_prog_counter,
    output logic [1:0]            o_status,
    output logic [7:0]            o_screen
);
    import tcis_pkg::*;

    function automatic logic signed [12:0] flt_decode(input logic [DW-1:0] b);
        logic [11:0] mag;
        mag = 12'(b[3:0]) << b[6:4];
        flt_decode = b[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic logic [DW-1:0] flt_encode(input logic signed [12:0] v);
        logic [11:0] mag;
        logic [3:0]  p;
        logic [3:0]  e;
        logic [11:0] sh;
        mag = v[12] ? 12'(-v) : v[11:0];
        p   = 4'd0;
        e   = 4'd0;
        sh  = 12'd0;
        for (int i = 0; i < 12; i++) begin
            if (mag[i]) begin
                p = 4'(i);
            end
        end
        if (mag == 12'd0) begin
            flt_encode = 8'h00;
        end else if (p > 4'd10) begin
            flt_encode = {v[12], 7'h7F};
        end else if (p < 4'd3) begin
            flt_encode = 8'h00;
        end else begin
            e          = p - 4'd3;
            sh         = mag >> e;
            flt_encode = {v[12], e[2:0], sh[3:0]};
        end
    endfunction

    logic [7:0]            r_addr;
    logic [7:0]            r_data;
    logic [7:0]            r_hi;
    logic [7:0]            r_lo;
    logic [7:0]            r_a;
    logic signed [12:0]    r_fsum;
    logic [7:0]            r_read_data;
    logic [7:0]            r_pc;
    t_run_status           r_status;
    logic [7:0]            r_screen;
    logic [MEM_DEPTH-1:0]  r_mem_vld;
    logic [REG_DEPTH-1:0]  r_reg_vld;
    logic                  r_mem_rvld;
    logic                  r_reg_rvld;

    logic [MEM_AW-1:0]     mem_raddr;
    logic [MEM_AW-1:0]     mem_waddr;
    logic [DW-1:0]         mem_wdata;
    logic [DW-1:0]         mem_q;
    logic [DW-1:0]         mem_qv;
    logic [REG_AW-1:0]     reg_raddr;
    logic [REG_AW-1:0]     reg_waddr;
    logic [DW-1:0]         reg_wdata;
    logic [DW-1:0]         reg_q;
    logic [DW-1:0]         reg_qv;
    logic [8:0]            pc_seq;
    logic [8:0]            pc_new;

    assign mem_qv = r_mem_rvld ? mem_q : '0;
    assign reg_qv = r_reg_rvld ? reg_q : '0;

    always_comb begin
        unique case (i_cmd.mem_ra)
            MRA_PC:   mem_raddr = r_pc;
            MRA_PC1:  mem_raddr = r_pc + 8'd1;
            MRA_LO:   mem_raddr = r_lo;
            MRA_ADDR: mem_raddr = r_addr;
            default:  mem_raddr = r_addr;
        endcase
        if (i_cmd.mem_wsrc == MWS_REG) begin
            mem_waddr = r_lo;
            mem_wdata = reg_qv;
        end else begin
            mem_waddr = r_addr;
            mem_wdata = r_data;
        end
        unique case (i_cmd.reg_ra)
            RRA_R:    reg_raddr = r_hi[3:0];
            RRA_S:    reg_raddr = r_lo[7:4];
            RRA_T:    reg_raddr = r_lo[3:0];
            RRA_ZERO: reg_raddr = '0;
            RRA_ADDR: reg_raddr = r_addr[REG_AW-1:0];
            default:  reg_raddr = '0;
        endcase
        reg_waddr = (i_cmd.reg_wsrc == RWS_MOVE) ? r_lo[3:0] : r_hi[3:0];
        unique case (i_cmd.reg_wsrc)
            RWS_MEM:  reg_wdata = mem_qv;
            RWS_LO:   reg_wdata = r_lo;
            RWS_MOVE: reg_wdata = reg_qv;
            RWS_ADD:  reg_wdata = r_a + reg_qv;
            RWS_FLT:  reg_wdata = flt_encode(r_fsum);
            default:  reg_wdata = r_lo;
        endcase
        pc_seq = {1'b0, r_pc} + 9'd2;
        unique case (i_cmd.pc_op)
            PCO_NEXT:   pc_new = pc_seq;
            PCO_BRANCH: pc_new = (r_a == reg_qv) ? {1'b0, r_lo} : pc_seq;
            default:    pc_new = {1'b0, r_pc};
        endcase
    end

    tcis_ram #(.WIDTH(DW), .DEPTH(MEM_DEPTH)) u_main_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    tcis_ram #(.WIDTH(DW), .DEPTH(REG_DEPTH)) u_reg_file (
        .i_clk   (i_clk),
        .i_we    (i_cmd.reg_we),
        .i_waddr (reg_waddr),
        .i_wdata (reg_wdata),
        .i_raddr (reg_raddr),
        .o_rdata (reg_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_addr <= i_addr;
            r_data <= i_data;
        end
        if (i_cmd.cap_hi) begin
            r_hi <= mem_qv;
        end
        if (i_cmd.cap_lo) begin
            r_lo <= mem_qv;
        end
        if (i_cmd.cap_a) begin
            r_a <= reg_qv;
        end
        if (i_cmd.cap_fsum) begin
            r_fsum <= flt_decode(r_a) + flt_decode(reg_qv);
        end
        priority if (i_cmd.load_req) begin
            r_read_data <= '0;
        end else if (i_cmd.cap_rd_mem) begin
            r_read_data <= mem_qv;
        end else if (i_cmd.cap_rd_reg) begin
            r_read_data <= reg_qv;
        end else begin
            r_read_data <= r_read_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_status   <= ST_RUN;
            r_screen   <= '0;
            r_mem_vld  <= '0;
            r_reg_vld  <= '0;
            r_mem_rvld <= 1'b0;
            r_reg_rvld <= 1'b0;
        end else begin
            r_mem_rvld <= r_mem_vld[mem_raddr];
            r_reg_rvld <= r_reg_vld[reg_raddr];
            if (i_cmd.mem_we) begin
                r_mem_vld[mem_waddr] <= 1'b1;
                if (mem_waddr == SCREEN_ADDR) begin
                    r_screen <= mem_wdata;
                end
            end
            if (i_cmd.reg_we) begin
                r_reg_vld[reg_waddr] <= 1'b1;
            end
            if (i_cmd.pc_op != PCO_HOLD) begin
                r_pc <= pc_new[7:0];
                if (pc_new > PC_LIMIT) begin
                    r_status <= ST_PCEND;
                end
            end
            unique case (i_cmd.st_op)
                STO_HALT:    r_status <= ST_HALT;
                STO_ILLEGAL: r_status <= ST_ILLEGAL;
                default:     ;
            endcase
        end
    end

    assign o_stat.op        = r_hi[7:4];
    assign o_stat.r_zero    = (r_hi[3:0] == 4'd0);
    assign o_stat.halt_word = ({r_hi, r_lo} == HALT_WORD);
    assign o_stat.running   = (r_status == ST_RUN);

    assign o_read_data    = r_read_data;
    assign o_prog_counter = r_pc;
    assign o_status       = r_status;
    assign o_screen       = r_screen;

endmodule

`default_nettype wire

// ----- rtl/core/tcis_ctrl.sv -----
// Controller of the teaching CPU step core: request intake, fetch, decode
// and per-opcode sequencing. Depends on tcis_pkg.
`default_nettype none

module tcis_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_cmd,
    input  tcis_pkg::t_dp_stat   i_stat,
    output logic                 o_busy,
    output logic                 o_done,
    output tcis_pkg::t_dp_cmd    o_cmd
);
    import tcis_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load_req = 1'b1;
                    unique case (t_cmd'(i_cmd))
                        CMD_MEM_WR: n_state = S_MWR;
                        CMD_MEM_RD: n_state = S_MRD;
                        CMD_REG_RD: n_state = S_RRD;
                        CMD_EXEC:   n_state = i_stat.running ? S_F1 : S_RESP;
                        default:    n_state = S_RESP;
                    endcase
                end
            end
            S_MWR: begin
                cmd.mem_we   = 1'b1;
                cmd.mem_wsrc = MWS_DATA;
                n_state      = S_RESP;
            end
            S_MRD: begin
                cmd.mem_ra = MRA_ADDR;
                n_state    = S_MRDC;
            end
            S_MRDC: begin
                cmd.cap_rd_mem = 1'b1;
                n_state        = S_RESP;
            end
            S_RRD: begin
                cmd.reg_ra = RRA_ADDR;
                n_state    = S_RRDC;
            end
            S_RRDC: begin
                cmd.cap_rd_reg = 1'b1;
                n_state        = S_RESP;
            end
            S_F1: begin
                cmd.mem_ra = MRA_PC;
                n_state    = S_F2;
            end
            S_F2: begin
                cmd.cap_hi = 1'b1;
                cmd.mem_ra = MRA_PC1;
                n_state    = S_F3;
            end
            S_F3: begin
                cmd.cap_lo = 1'b1;
                n_state    = S_DEC;
            end
            S_DEC: begin
                n_state = S_RESP;
                unique case (i_stat.op)
                    OP_LOAD: begin
                        cmd.mem_ra = MRA_LO;
                        n_state    = S_LDW;
                    end
                    OP_IMM: begin
                        cmd.reg_we   = 1'b1;
                        cmd.reg_wsrc = RWS_LO;
                        cmd.pc_op    = PCO_NEXT;
                    end
                    OP_STORE: begin
                        cmd.reg_ra = RRA_R;
                        n_state    = S_STW;
                    end
                    OP_MOVE: begin
                        if (i_stat.r_zero) begin
                            cmd.reg_ra = RRA_S;
                            n_state    = S_MVW;
                        end else begin
                            cmd.st_op = STO_ILLEGAL;
                        end
                    end
                    OP_ADD, OP_FADD: begin
                        cmd.reg_ra = RRA_S;
                        n_state    = S_AB;
                    end
                    OP_JEQ: begin
                        cmd.reg_ra = RRA_R;
                        n_state    = S_AB;
                    end
                    OP_HALT: begin
                        cmd.st_op = i_stat.halt_word ? STO_HALT : STO_ILLEGAL;
                    end
                    default: begin
                        cmd.st_op = STO_ILLEGAL;
                    end
                endcase
            end
            S_LDW: begin
                cmd.reg_we   = 1'b1;
                cmd.reg_wsrc = RWS_MEM;
                cmd.pc_op    = PCO_NEXT;
                n_state      = S_RESP;
            end
            S_STW: begin
                cmd.mem_we   = 1'b1;
                cmd.mem_wsrc = MWS_REG;
                cmd.pc_op    = PCO_NEXT;
                n_state      = S_RESP;
            end
            S_MVW: begin
                cmd.reg_we   = 1'b1;
                cmd.reg_wsrc = RWS_MOVE;
                cmd.pc_op    = PCO_NEXT;
                n_state      = S_RESP;
            end
            S_AB: begin
                cmd.cap_a  = 1'b1;
                cmd.reg_ra = (i_stat.op == OP_JEQ) ? RRA_ZERO : RRA_T;
                n_state    = S_EX;
            end
            S_EX: begin
                n_state = S_RESP;
                unique case (i_stat.op)
                    OP_ADD: begin
                        cmd.reg_we   = 1'b1;
                        cmd.reg_wsrc = RWS_ADD;
                        cmd.pc_op    = PCO_NEXT;
                    end
                    OP_FADD: begin
                        cmd.cap_fsum = 1'b1;
                        n_state      = S_FWB;
                    end
                    OP_JEQ: begin
                        cmd.pc_op = PCO_BRANCH;
                    end
                    default: ;
                endcase
            end
            S_FWB: begin
                cmd.reg_we   = 1'b1;
                cmd.reg_wsrc = RWS_FLT;
                cmd.pc_op    = PCO_NEXT;
                n_state      = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);

endmodule

`default_nettype wire

// ----- rtl/core/teaching_cpu_instruction_step_core.sv -----
// Top level of the teaching CPU step core: controller plus datapath.
// Depends on tcis_pkg, tcis_ctrl, tcis_dpath (and through it tcis_ram).
//
// One request is taken when start is high and busy is low; its single result
// appears on the o_ ports for exactly one cycle with o_done high, and the
// receiver cannot stall it, so sample it in that cycle. Busy stays high from
// the cycle after acceptance through the o_done cycle, so a new request can
// be taken the cycle after o_done. Before S_RESP: memory write S_MWR; memory
// read S_MRD, S_MRDC; register read S_RRD, S_RRDC; halted execute none;
// execute S_F1..S_F3, S_DEC, then S_LDW, S_STW or S_MVW (load, store, move),
// S_AB, S_EX (add, jump; float add adds S_FWB) or none (immediate). The
// store's single read port fetches the two instruction bytes in consecutive
// cycles, the register file's one operand per cycle. Storage is ready right
// after reset: reset clears per-entry valid bits, with no clearing pass.
`default_nettype none

module teaching_cpu_instruction_step_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_addr,
    input  logic [7:0] i_data,
    output logic       o_done,
    output logic [7:0] o_read_data,
    output logic [7:0] o_prog_counter,
    output logic [1:0] o_status,
    output logic [7:0] o_screen
);
    import tcis_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    tcis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (dp_stat),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd)
    );

    tcis_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_addr         (i_addr),
        .i_data         (i_data),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_read_data    (o_read_data),
        .o_prog_counter (o_prog_counter),
        .o_status       (o_status),
        .o_screen       (o_screen)
    );

endmodule

`default_nettype wire

// ----- rtl/core/tcis_chk.sv -----
// Port-level checker for the teaching CPU step core, bound to the top level.
// Depends on tcis_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcis_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_status
);
    import tcis_pkg::*;

    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_SAME(a_done_busy, i_clk, i_rst_n, o_done, busy)
    `ASSERT_NEXT(a_busy_until_done, i_clk, i_rst_n, busy && !o_done, busy)
    `ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, o_status != ST_RUN, o_status == $past(o_status))

endmodule

bind teaching_cpu_instruction_step_core tcis_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_status (o_status)
);

`default_nettype wire
